### rtl/core/cng_pkg.sv
// ----------------------------------------------------------------------------
// cng_pkg: shared definitions of the character n-gram counter
// Constants, command and status codes, and the cell bus types.
// ----------------------------------------------------------------------------
package cng_pkg;

  localparam int MAX_GRAM    = 8;
  localparam int TABLE_DEPTH = 64;
  localparam int COUNT_BITS  = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int USED_W      = $clog2(TABLE_DEPTH + 1);
  localparam int LEN_W       = 4;
  localparam int KEY_W       = 8 * MAX_GRAM;

  typedef enum logic [1:0] {
    CMD_CHAR  = 2'd0,
    CMD_EOL   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_NONE    = 2'd0,
    STAT_COUNTED = 2'd1,
    STAT_DROPPED = 2'd2,
    STAT_READ    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_CMP   = 3'd1,
    OP_UPD   = 3'd2,
    OP_LOAD  = 3'd3,
    OP_SHIFT = 3'd4
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic             ins;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
  } bcast_t;

  typedef struct packed {
    logic                  valid;
    logic [KEY_W-1:0]      key;
    logic [LEN_W-1:0]      len;
    logic [COUNT_BITS-1:0] cnt;
  } entry_t;

  typedef logic [MAX_GRAM-1:0][7:0] window_t;

  function automatic logic [KEY_W-1:0] suffix_key(window_t win, logic [LEN_W-1:0] len);
    logic [KEY_W-1:0] key;
    key = '0;
    for (int j = 0; j < MAX_GRAM; j++) begin
      if (LEN_W'(j) < len) begin
        key[8*j +: 8] = win[$clog2(MAX_GRAM)'(len - LEN_W'(j) - LEN_W'(1))];
      end
    end
    return key;
  endfunction

endpackage

### rtl/core/cng_cell.sv
// ----------------------------------------------------------------------------
// cng_cell: one table entry of the n-gram counter
// Holds key, length and count, compares against the broadcast n-gram,
// updates or takes a new entry, and forms one stage of the readout chain.
// ----------------------------------------------------------------------------
module cng_cell
  import cng_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bcast_t            bcast_i,
  input  logic [IDX_W-1:0]  cell_idx_i,
  input  logic [USED_W-1:0] used_i,
  input  entry_t            shift_i,
  output entry_t            shift_o,
  output logic              match_o
);

  logic [KEY_W-1:0]      key_q;
  logic [LEN_W-1:0]      len_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic                  match_q;
  entry_t                sh_q;
  logic                  in_use;

  assign in_use  = USED_W'(cell_idx_i) < used_i;
  assign match_o = match_q;
  assign shift_o = sh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (bcast_i.op == OP_CMP) begin
      match_q <= in_use && (key_q == bcast_i.key) && (len_q == bcast_i.len);
    end else if (bcast_i.op == OP_UPD) begin
      match_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (bcast_i.op)
      OP_UPD: begin
        if (match_q) begin
          if (cnt_q != {COUNT_BITS{1'b1}}) begin
            cnt_q <= cnt_q + COUNT_BITS'(1);
          end
        end else if (bcast_i.ins && (USED_W'(cell_idx_i) == used_i)) begin
          key_q <= bcast_i.key;
          len_q <= bcast_i.len;
          cnt_q <= COUNT_BITS'(1);
        end
      end
      OP_LOAD: begin
        sh_q <= '{valid: in_use, key: key_q, len: len_q, cnt: cnt_q};
      end
      OP_SHIFT: begin
        sh_q <= shift_i;
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/char_ngram_counter_top.sv
// ----------------------------------------------------------------------------
// char_ngram_counter_top: character n-gram frequency counter
// Window of recent bytes, control sequencer and a row of table cells.
// ----------------------------------------------------------------------------
// Each request yields exactly one response. A character that closes an
// n-gram passes through a compare state (compare in all cells) and an
// update state; other characters and clears go straight to the response.
// An end of line runs one compare and update pair per tail n-gram, up to
// seven. A read of an entry in use loads all cells into the readout chain
// and shifts it toward cell zero until the entry is there; a read past the
// last used entry goes straight out. Requests are taken one at a time.
module char_ngram_counter_top
  import cng_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // char_byte [7:0], entry_index [13:8]
  input  logic [1:0]  s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // entry_valid, entry_key, entry_length,
                                      // entry_count, distinct_used
  output logic [1:0]  m_axis_tuser,   // status
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [3:0]  cfg_data_i
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_CMP     = 6'b000010,
    ST_UPD     = 6'b000100,
    ST_RDLOAD  = 6'b001000,
    ST_RDSHIFT = 6'b010000,
    ST_OUT     = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  window_t            win_q, win_d;
  logic [LEN_W-1:0]   cil_q, cil_d;
  logic [USED_W-1:0]  used_q, used_d;
  logic [LEN_W-1:0]   glen_q, gram_q, gram_d;
  logic               icase_q, eol_q, eol_d, drop_q, drop_d;
  logic [IDX_W-1:0]   rd_q, rd_d;
  status_e            res_stat_q, res_stat_d;
  entry_t             res_q, res_d;
  logic               mval_q;
  status_e            mstat_q;
  entry_t             ment_q;
  logic [USED_W-1:0]  mused_q;

  logic [LEN_W-1:0]       n_eff, tail;
  logic [7:0]             ch;
  logic                   accept, hit, full, out_load;
  cmd_e                   cmd;
  bcast_t                 bcast;
  logic [TABLE_DEPTH-1:0] match;
  entry_t                 chain [TABLE_DEPTH+1];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cmd           = cmd_e'(s_axis_tuser);
  assign out_load      = (state_q == ST_OUT) && (!mval_q || m_axis_tready);

  assign m_axis_tvalid = mval_q;
  assign m_axis_tuser  = mstat_q;
  assign m_axis_tdata  = {4'd0, mused_q, ment_q.cnt, ment_q.len, ment_q.key, ment_q.valid};

  always_comb begin
    if (glen_q == '0) begin
      n_eff = LEN_W'(1);
    end else if (glen_q > LEN_W'(MAX_GRAM)) begin
      n_eff = LEN_W'(MAX_GRAM);
    end else begin
      n_eff = glen_q;
    end
  end

  assign ch   = (icase_q && s_axis_tdata[7:0] >= 8'h41 && s_axis_tdata[7:0] <= 8'h5A)
              ? s_axis_tdata[7:0] + 8'd32 : s_axis_tdata[7:0];
  assign tail = (cil_q >= n_eff) ? n_eff - LEN_W'(1) : cil_q;
  assign hit  = |match;
  assign full = (used_q == USED_W'(TABLE_DEPTH));

  always_comb begin
    bcast.op  = OP_IDLE;
    bcast.ins = !hit && !full;
    bcast.key = suffix_key(win_q, gram_q);
    bcast.len = gram_q;
    case (state_q)
      ST_CMP:     bcast.op = OP_CMP;
      ST_UPD:     bcast.op = OP_UPD;
      ST_RDLOAD:  bcast.op = OP_LOAD;
      ST_RDSHIFT: bcast.op = (rd_q == '0) ? OP_IDLE : OP_SHIFT;
      default:    bcast.op = OP_IDLE;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    win_d      = win_q;
    cil_d      = cil_q;
    used_d     = used_q;
    gram_d     = gram_q;
    eol_d      = eol_q;
    drop_d     = drop_q;
    rd_d       = rd_q;
    res_stat_d = res_stat_q;
    res_d      = res_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_stat_d = STAT_NONE;
          res_d      = '0;
          drop_d     = 1'b0;
          state_d    = ST_OUT;
          case (cmd)
            CMD_CHAR: begin
              win_d = {win_q[MAX_GRAM-2:0], ch};
              if (cil_q < LEN_W'(MAX_GRAM)) begin
                cil_d = cil_q + LEN_W'(1);
              end
              eol_d  = 1'b0;
              gram_d = n_eff;
              if (cil_d >= n_eff) begin
                state_d = ST_CMP;
              end
            end
            CMD_EOL: begin
              eol_d  = 1'b1;
              gram_d = tail;
              if (tail != '0) begin
                state_d = ST_CMP;
              end else begin
                win_d = '0;
                cil_d = '0;
              end
            end
            CMD_READ: begin
              res_stat_d = STAT_READ;
              rd_d       = s_axis_tdata[8 +: IDX_W];
              if (USED_W'(s_axis_tdata[8 +: IDX_W]) < used_q) begin
                state_d = ST_RDLOAD;
              end
            end
            default: begin
              used_d = '0;
            end
          endcase
        end
      end
      ST_CMP: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (!hit && full) begin
          drop_d = 1'b1;
        end
        if (bcast.ins) begin
          used_d = used_q + USED_W'(1);
        end
        if (eol_q && gram_q > LEN_W'(1)) begin
          gram_d  = gram_q - LEN_W'(1);
          state_d = ST_CMP;
        end else begin
          res_stat_d = drop_d ? STAT_DROPPED : STAT_COUNTED;
          if (eol_q) begin
            win_d = '0;
            cil_d = '0;
          end
          state_d = ST_OUT;
        end
      end
      ST_RDLOAD: begin
        state_d = ST_RDSHIFT;
      end
      ST_RDSHIFT: begin
        if (rd_q == '0) begin
          res_d   = chain[0];
          state_d = ST_OUT;
        end else begin
          rd_d = rd_q - IDX_W'(1);
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      win_q   <= '0;
      cil_q   <= '0;
      used_q  <= '0;
      glen_q  <= LEN_W'(2);
      icase_q <= 1'b0;
      mval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      win_q   <= win_d;
      cil_q   <= cil_d;
      used_q  <= used_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i) begin
          icase_q <= cfg_data_i[0];
        end else begin
          glen_q <= cfg_data_i;
        end
      end
      if (out_load) begin
        mval_q <= 1'b1;
      end else if (m_axis_tready) begin
        mval_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    gram_q     <= gram_d;
    eol_q      <= eol_d;
    drop_q     <= drop_d;
    rd_q       <= rd_d;
    res_stat_q <= res_stat_d;
    res_q      <= res_d;
    if (out_load) begin
      mstat_q <= res_stat_q;
      ment_q  <= res_q;
      mused_q <= used_q;
    end
  end

  assign chain[TABLE_DEPTH] = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    cng_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .bcast_i    (bcast),
      .cell_idx_i (IDX_W'(i)),
      .used_i     (used_q),
      .shift_i    (chain[i+1]),
      .shift_o    (chain[i]),
      .match_o    (match[i])
    );
  end

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= USED_W'(TABLE_DEPTH))
    else $error("table fill count exceeds depth");

  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPD |-> $onehot0(match))
    else $error("n-gram matched more than one entry");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd == CMD_CLEAR |=> used_q == '0)
    else $error("clear did not empty the table");

  a_read_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RDSHIFT && rd_q == '0 |-> chain[0].valid)
    else $error("readout chain delivered an unused entry");

endmodule

### tb/tb_char_ngram_counter_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_char_ngram_counter_top: self-checking bench of the n-gram counter
// Text lines, line ends, table reads and clears are streamed in with random
// gaps and output stalls. A behavioral copy of the counter predicts each
// response, which is then compared field by field.
// ----------------------------------------------------------------------------
module tb_char_ngram_counter_top;
  import cng_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam bit REG_GRAM = 1'b0;
  localparam bit REG_CASE = 1'b1;

  typedef struct {
    status_e          status;
    bit               valid;
    logic [KEY_W-1:0] key;
    logic [3:0]       len;
    logic [15:0]      cnt;
    logic [6:0]       used;
  } response_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [3:0]  cfg_data_i = '0;

  char_ngram_counter_top DUT (.*);

  always #5 clk_i = ~clk_i;

  // Predicted state of the counter.
  logic [7:0]       win [MAX_GRAM];
  int               chars_seen;
  logic [KEY_W-1:0] tbl_key [TABLE_DEPTH];
  logic [3:0]       tbl_len [TABLE_DEPTH];
  logic [15:0]      tbl_cnt [TABLE_DEPTH];
  int               tbl_used;
  int               gram_reg = 2;
  bit               case_reg = 1'b0;

  response_t pending_q[$];
  int errors = 0;
  int requests = 0;
  int checked = 0;
  int drops = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  function automatic bit tally_ngram(int len);
    logic [KEY_W-1:0] key;
    key = '0;
    for (int j = 0; j < len; j++) key[8*j +: 8] = win[len-1-j];
    for (int i = 0; i < tbl_used; i++) begin
      if (tbl_key[i] == key && tbl_len[i] == len) begin
        if (tbl_cnt[i] != 16'hFFFF) tbl_cnt[i]++;
        return 1'b1;
      end
    end
    if (tbl_used >= TABLE_DEPTH) return 1'b0;
    tbl_key[tbl_used] = key;
    tbl_len[tbl_used] = 4'(len);
    tbl_cnt[tbl_used] = 16'd1;
    tbl_used++;
    return 1'b1;
  endfunction

  function automatic response_t predict_response(cmd_e cmd, logic [7:0] ch, logic [5:0] idx);
    response_t r;
    int g;
    int t;
    bit dropped;
    logic [7:0] c;
    r = '{STAT_NONE, 1'b0, '0, '0, '0, '0};
    g = (gram_reg == 0) ? 1 : (gram_reg > MAX_GRAM) ? MAX_GRAM : gram_reg;
    case (cmd)
      CMD_CHAR: begin
        c = ch;
        if (case_reg && c >= "A" && c <= "Z") c = c + 8'd32;
        for (int i = MAX_GRAM - 1; i > 0; i--) win[i] = win[i-1];
        win[0] = c;
        if (chars_seen < MAX_GRAM) chars_seen++;
        if (chars_seen >= g) r.status = tally_ngram(g) ? STAT_COUNTED : STAT_DROPPED;
      end
      CMD_EOL: begin
        t = (chars_seen >= g) ? g - 1 : chars_seen;
        dropped = 1'b0;
        if (t > 0) r.status = STAT_COUNTED;
        for (; t > 0; t--) if (!tally_ngram(t)) dropped = 1'b1;
        if (dropped) r.status = STAT_DROPPED;
        for (int i = 0; i < MAX_GRAM; i++) win[i] = 8'd0;
        chars_seen = 0;
      end
      CMD_READ: begin
        r.status = STAT_READ;
        if (idx < tbl_used) begin
          r.valid = 1'b1;
          r.key = tbl_key[idx];
          r.len = tbl_len[idx];
          r.cnt = tbl_cnt[idx];
        end
      end
      default: tbl_used = 0;
    endcase
    r.used = 7'(tbl_used);
    return r;
  endfunction

  task automatic send_req(cmd_e cmd, logic [7:0] ch = 8'd0, logic [5:0] idx = 6'd0);
    int gap;
    response_t r;
    gap = 0;
    if (!no_gaps) begin
      case ($urandom_range(9))
        0, 1, 2: gap = $urandom_range(1, 3);
        3: gap = $urandom_range(5, 30);
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {2'b00, idx, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    r = predict_response(cmd, ch, idx);
    if (r.status == STAT_DROPPED) drops++;
    pending_q = {pending_q, r};
    requests++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(bit index, logic [3:0] value);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (index == REG_GRAM) gram_reg = value;
    else case_reg = value[0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_line(string s);
    foreach (s[i]) send_req(CMD_CHAR, s[i]);
    send_req(CMD_EOL);
  endtask

  always @(negedge clk_i) begin
    if (hold_req && hold_left == 0) hold_left = HOLD_CYCLES;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (no_gaps) begin
      m_axis_tready <= 1'b1;
    end else begin
      if ($urandom_range(39) == 0) hold_left = $urandom_range(5, 30);
      m_axis_tready <= ($urandom_range(9) < 7) || ($urandom_range(19) == 0);
    end
  end

  always @(posedge clk_i) begin
    response_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        $error("Response with no request outstanding");
        errors++;
      end else begin
        e = pending_q.pop_front();
        checked++;
        if (m_axis_tuser != e.status) begin
          $error("status: expected %0d, actual %0d", e.status, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[0] != e.valid) begin
          $error("entry_valid: expected %0d, actual %0d", e.valid, m_axis_tdata[0]);
          errors++;
        end
        if (m_axis_tdata[64:1] != e.key) begin
          $error("entry_key: expected %h, actual %h", e.key, m_axis_tdata[64:1]);
          errors++;
        end
        if (m_axis_tdata[68:65] != e.len) begin
          $error("entry_length: expected %0d, actual %0d", e.len, m_axis_tdata[68:65]);
          errors++;
        end
        if (m_axis_tdata[84:69] != e.cnt) begin
          $error("entry_count: expected %0d, actual %0d", e.cnt, m_axis_tdata[84:69]);
          errors++;
        end
        if (m_axis_tdata[91:85] != e.used) begin
          $error("distinct_used: expected %0d, actual %0d", e.used, m_axis_tdata[91:85]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d cycles without progress", IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_basic_counting();
    send_line("abab");
    send_req(CMD_EOL);
    send_req(CMD_CHAR, 8'h00);
    send_req(CMD_CHAR, 8'hFF);
    send_req(CMD_CHAR, 8'h00);
    send_req(CMD_EOL);
    send_req(CMD_CHAR, 8'h00);
    send_req(CMD_EOL);
    for (int i = 0; i < 8; i++) send_req(CMD_READ, 8'd0, 6'(i));
    send_req(CMD_READ, 8'hFF, 6'd63);
    send_req(CMD_CLEAR);
    send_req(CMD_READ, 8'd0, 6'd0);
  endtask

  task automatic test_registers();
    send_req(CMD_CHAR, "Q");
    send_req(CMD_CHAR, "z");
    write_reg(REG_CASE, 4'd1);
    send_req(CMD_CHAR, "Q");
    send_req(CMD_CHAR, "@");
    send_req(CMD_CHAR, "[");
    send_req(CMD_EOL);
    write_reg(REG_GRAM, 4'd8);
    send_line("ABCDEFGHIJ");
    send_line("xyz");
    write_reg(REG_GRAM, 4'd0);
    send_line("Aa");
    write_reg(REG_GRAM, 4'd15);
    send_line("abcdefghi");
    write_reg(REG_GRAM, 4'd1);
    write_reg(REG_CASE, 4'd0);
    send_line("Aa");
    for (int i = 0; i < 4; i++) send_req(CMD_READ, 8'd0, 6'($urandom_range(40)));
    send_req(CMD_CLEAR);
  endtask

  task automatic test_table_full();
    write_reg(REG_GRAM, 4'd1);
    for (int i = 0; i < 70; i++) send_req(CMD_CHAR, 8'(i * 3));
    send_req(CMD_CHAR, 8'd0);
    send_req(CMD_EOL);
    write_reg(REG_GRAM, 4'd3);
    send_line("abcd");
    send_req(CMD_READ, 8'd0, 6'd63);
    send_req(CMD_READ, 8'd0, 6'd0);
    send_req(CMD_CLEAR);
  endtask

  task automatic test_random_text(int n_items);
    int sent;
    int len;
    logic [7:0] ch;
    sent = 0;
    while (sent < n_items) begin
      if (sent % 110 < 8) begin
        write_reg(REG_GRAM, 4'($urandom_range(15)));
        write_reg(REG_CASE, 4'($urandom_range(1)));
        no_gaps = ($urandom_range(3) == 0);
      end
      len = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(3))
          0: ch = 8'($urandom_range(255));
          1: ch = "A" + 8'($urandom_range(3));
          default: ch = "a" + 8'($urandom_range(3));
        endcase
        send_req(CMD_CHAR, ch);
      end
      send_req(CMD_EOL);
      sent += len + 1;
      if ($urandom_range(2) == 0) begin
        send_req(CMD_READ, 8'($urandom_range(255)), 6'($urandom_range(tbl_used > 0 ? 63 : 0)));
        sent++;
      end
      if ($urandom_range(25) == 0) begin
        send_req(CMD_CLEAR);
        sent++;
      end
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_backpressure();
    drain();
    hold_req = 1'b1;
    no_gaps = 1'b1;
    wait (hold_left != 0);
    hold_req = 1'b0;
    for (int i = 0; i < 40; i++) send_req(CMD_CHAR, 8'($urandom_range(255)));
    send_req(CMD_EOL);
    no_gaps = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < MAX_GRAM; i++) win[i] = 8'd0;
    chars_seen = 0;
    tbl_used = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_basic_counting();
    test_registers();
    test_table_full();
    test_random_text(460);
    test_backpressure();
    drain();
    repeat (80) @(posedge clk_i);
    $display("Run covered %0d requests and %0d checked responses, with %0d table-full drops,",
             requests, checked, drops);
    $display("gram lengths 0 to 15, case folding on and off, and a long output stall.");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
